FILE: src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths and codes for the random sample set.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int DATA_W   = 32;
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ITER_W   = $clog2(DATA_W);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

FILE: src/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rss_mod.sv
// ----------------------------------------------------------------------------
// rss_mod
// Bit-serial remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rss_mod
  import rss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CNT_W-1:0]  rem
);

  logic              running;
  logic [ITER_W-1:0] iter;
  logic [DATA_W-1:0] dvd;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic [CNT_W-1:0]  rem_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem, dvd[DATA_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = rem_sub[CNT_W-1:0];
    end else begin
      rem_next = rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= '0;
      end else if (running) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(DATA_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

FILE: src/random_sample_set.sv
// ----------------------------------------------------------------------------
// random_sample_set
// Set of distinct 32-bit values with insert, remove and random pick.
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. Values sit
// densely in a 64-entry RAM, and membership is found by reading the entries
// through the one RAM read port, one per cycle, until the value is found or
// every member has been read. A remove whose value is not in the last entry
// then reads the last entry and moves it into the freed slot. A random pick
// runs the bit-serial remainder unit (32 steps) on random_word modulo the
// member count, then one RAM read at the remainder. Operation code 3 and a
// pick from an empty set answer in the cycle after acceptance. The RAM
// contents need no clearing after reset; the count and control state are reset.
module random_sample_set
  import rss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic [31:0]        random_word,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] picked_value
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SRCH    = 3'd1;
  localparam logic [2:0] S_RDLAST  = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_MOD     = 3'd4;
  localparam logic [2:0] S_PICK    = 3'd5;
  localparam logic [2:0] S_PICKOUT = 3'd6;

  logic [2:0]        state;
  logic [1:0]        cur_op;
  logic [DATA_W-1:0] cur_value;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_idx;
  logic [ADDR_W-1:0] slot;

  logic [CNT_W-1:0]  last;
  logic              full;
  logic              hit;
  logic              miss;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;

  assign busy = (state != S_IDLE);
  assign last = count - 1'b1;
  assign full = (count == CNT_W'(CAPACITY));

  // rdata is the registered read of the address issued the cycle before, so a hit belongs to pend_idx
  assign hit  = pend_valid && (rdata == cur_value);
  assign miss = !pend_valid && (rd_idx == count);

  assign mod_start = start && !busy && (operation == OP_PICK) && (count != '0);

  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = cur_value;
    if (state == S_SRCH && !hit && miss && cur_op == OP_INSERT && !full) begin
      we = 1'b1;
    end else if (state == S_MOVE) begin
      we    = 1'b1;
      waddr = slot;
      wdata = rdata;
    end
  end

  always_comb begin
    case (state)
      S_RDLAST: raddr = last[ADDR_W-1:0];
      S_PICK:   raddr = mod_rem[ADDR_W-1:0];
      default:  raddr = rd_idx[ADDR_W-1:0];
    endcase
  end

  rss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rss_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (random_word),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op     <= operation;
            cur_value  <= value;
            rd_idx     <= '0;
            pend_valid <= 1'b0;
            case (operation)
              OP_INSERT, OP_REMOVE: begin
                state <= S_SRCH;
              end
              OP_PICK: begin
                if (count == '0) begin
                  done         <= 1'b1;
                  status       <= ST_EMPTY;
                  picked_value <= '1;
                end else begin
                  state <= S_MOD;
                end
              end
              default: begin
                done         <= 1'b1;
                status       <= ST_DONE;
                picked_value <= '0;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (hit) begin
            pend_valid <= 1'b0;
            if (cur_op == OP_INSERT) begin
              done         <= 1'b1;
              status       <= ST_MISS;
              picked_value <= '0;
              state        <= S_IDLE;
            end else if (pend_idx == last[ADDR_W-1:0]) begin
              count        <= last;
              done         <= 1'b1;
              status       <= ST_DONE;
              picked_value <= '0;
              state        <= S_IDLE;
            end else begin
              slot  <= pend_idx;
              state <= S_RDLAST;
            end
          end else if (miss) begin
            done         <= 1'b1;
            picked_value <= '0;
            state        <= S_IDLE;
            if (cur_op == OP_INSERT) begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                status <= ST_DONE;
                count  <= count + 1'b1;
              end
            end else begin
              status <= ST_MISS;
            end
          end else if (rd_idx < count) begin
            rd_idx     <= rd_idx + 1'b1;
            pend_valid <= 1'b1;
            pend_idx   <= rd_idx[ADDR_W-1:0];
          end else begin
            pend_valid <= 1'b0;
          end
        end
        S_RDLAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          count        <= last;
          done         <= 1'b1;
          status       <= ST_DONE;
          picked_value <= '0;
          state        <= S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          state <= S_PICKOUT;
        end
        S_PICKOUT: begin
          done         <= 1'b1;
          status       <= ST_DONE;
          picked_value <= rdata;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
